// ===== rtl/core/kpa_pkg.sv =====
// shared types and constants for the keyed position accumulator
package kpa_pkg;

    localparam int KEY_W  = 160;
    localparam int NET_W  = 48;
    localparam int QTY_W  = 32;
    localparam int SLOT_W = 6;

    localparam logic [1:0] STATUS_HIT  = 2'd0;
    localparam logic [1:0] STATUS_NEW  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [63:0]        customer_high;
        logic [63:0]        customer_low;
        logic [31:0]        instrument;
        logic signed [31:0] quantity;
        logic [31:0]        price;
    } fill_t;

    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic [1:0]              status;
        logic signed [NET_W-1:0] net_position;
        logic [31:0]             average_cost;
    } result_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic             active;
        logic             hit;
        logic             free;
        logic [NET_W-1:0] net;
    } tok_t;

    // update broadcast to the row
    typedef struct packed {
        logic             en;
        logic             claim;
        logic [NET_W-1:0] net;
    } wr_t;

endpackage

// ===== rtl/core/kpa_cell.sv =====
// one table entry of the position row, with its stage of the search chain
module kpa_cell
    import kpa_pkg::*;
#(
    parameter int IW  = 6,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  key_t          key,
    input  tok_t          tok_in,
    input  logic [IW-1:0] slot_in,
    output tok_t          tok_out,
    output logic [IW-1:0] slot_out,
    input  wr_t           wr,
    input  logic [IW-1:0] wr_slot
);

    logic             valid_reg;
    key_t             key_reg;
    logic [NET_W-1:0] net_reg;
    logic             active_reg;
    tok_t             tok_reg;
    logic [IW-1:0]    slot_reg;
    tok_t             tok_next;
    logic [IW-1:0]    slot_next;
    logic             hit_here;
    logic             free_here;
    logic             wr_sel;

    assign hit_here  = tok_in.active && !tok_in.hit && valid_reg && (key_reg == key);
    assign free_here = tok_in.active && !tok_in.hit && !tok_in.free && !valid_reg;
    assign wr_sel    = wr.en && (wr_slot == IW'(IDX));

    always_comb
    begin
        tok_next  = tok_in;
        slot_next = slot_in;
        if (hit_here)
        begin
            tok_next.hit = 1'b1;
            tok_next.net = net_reg;
            slot_next    = IW'(IDX);
        end
        else if (free_here)
        begin
            // remember the lowest free entry, a later hit still wins
            tok_next.free = 1'b1;
            slot_next     = IW'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= tok_in.active;
            if (wr_sel)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        slot_reg <= slot_next;
        if (wr_sel)
        begin
            net_reg <= wr.net;
            if (wr.claim)
            begin
                key_reg <= key;
            end
        end
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = active_reg;
    end

    assign slot_out = slot_reg;

endmodule

// ===== rtl/core/keyed_position_accumulator.sv =====
// Position table keyed by customer id and instrument, one entry per cell in a row of ENTRIES
// cells. A fill launches a search token that walks the row one cell per cycle, picking up
// the matching entry or else the lowest free one; at the end of the row the saturated net
// position is computed and written back to the chosen cell when there is one. A new fill is
// accepted only after the last has finished, since the block stays busy while the token walks
// the row and through the finish step. The result sits in an output register, so the next fill
// is taken while a result still waits. Valid bits clear at reset; no clearing pass.
module keyed_position_accumulator
    import kpa_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fill_valid,
    output logic    fill_stall,
    input  fill_t   fill,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int IW = $clog2(ENTRIES);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FINISH} state_t;

    state_t           state_reg;
    logic             inj_reg;
    logic             result_valid_reg;
    result_t          result_reg;
    fill_t            item_reg;
    logic             fin_hit_reg;
    logic             fin_free_reg;
    logic [IW-1:0]    fin_slot_reg;
    logic [NET_W-1:0] fin_net_reg;

    tok_t             chain_tok  [ENTRIES+1];
    logic [IW-1:0]    chain_slot [ENTRIES+1];
    logic [ENTRIES-1:0] active_vec;
    key_t             key;
    wr_t              wr;
    logic             fill_take;
    logic             out_free;
    logic             finish_go;
    logic             last_arrive;
    logic [NET_W-1:0] base_net;
    logic [NET_W:0]   sum_wide;
    logic [NET_W-1:0] sum_sat;
    result_t          result_next;

    assign key         = {item_reg.customer_high, item_reg.customer_low, item_reg.instrument};
    assign fill_take   = fill_valid && !fill_stall;
    assign fill_stall  = (state_reg != ST_IDLE);
    assign out_free    = !result_valid_reg || !result_stall;
    assign finish_go   = (state_reg == ST_FINISH) && out_free;
    assign last_arrive = (state_reg == ST_WALK) && chain_tok[ENTRIES].active;

    assign chain_tok[0]  = '{active: inj_reg, hit: 1'b0, free: 1'b0, net: '0};
    assign chain_slot[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kpa_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key),
            .tok_in   (chain_tok[i]),
            .slot_in  (chain_slot[i]),
            .tok_out  (chain_tok[i+1]),
            .slot_out (chain_slot[i+1]),
            .wr       (wr),
            .wr_slot  (fin_slot_reg)
        );
        assign active_vec[i] = chain_tok[i+1].active;
    end

    // a claimed entry starts from zero
    assign base_net = fin_hit_reg ? fin_net_reg : '0;
    assign sum_wide = {base_net[NET_W-1], base_net}
                    + {{(NET_W+1-QTY_W){item_reg.quantity[QTY_W-1]}}, item_reg.quantity};

    always_comb
    begin
        if (sum_wide[NET_W] != sum_wide[NET_W-1])
        begin
            sum_sat = sum_wide[NET_W] ? {1'b1, {(NET_W-1){1'b0}}} : {1'b0, {(NET_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[NET_W-1:0];
        end
    end

    always_comb
    begin
        wr.en    = finish_go && (fin_hit_reg || fin_free_reg);
        wr.claim = !fin_hit_reg;
        wr.net   = sum_sat;
    end

    always_comb
    begin
        if (fin_hit_reg || fin_free_reg)
        begin
            result_next.slot         = SLOT_W'(fin_slot_reg);
            result_next.status       = fin_hit_reg ? STATUS_HIT : STATUS_NEW;
            result_next.net_position = sum_sat;
            result_next.average_cost = item_reg.price;
        end
        else
        begin
            result_next.slot         = '0;
            result_next.status       = STATUS_FULL;
            result_next.net_position = '0;
            result_next.average_cost = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            inj_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // a fill is taken only while idle, so this launches one token per transaction
            inj_reg <= fill_take;
            if (finish_go)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (fill_take)
                    begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (last_arrive)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (finish_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_take)
        begin
            item_reg <= fill;
        end
        if (last_arrive)
        begin
            fin_hit_reg  <= chain_tok[ENTRIES].hit;
            fin_free_reg <= chain_tok[ENTRIES].free;
            fin_slot_reg <= chain_slot[ENTRIES];
            fin_net_reg  <= chain_tok[ENTRIES].net;
        end
        if (finish_go)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // only one search token is ever in the row
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(active_vec))
        else $error("more than one search token in the row");

    // the token leaves the row only while a walk is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_tok[ENTRIES].active |-> state_reg == ST_WALK)
        else $error("search token left the row outside a walk");

    // a table update always comes with a result that is not FULL, valid in the cycle after the write
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> result_valid_reg && result_reg.status != STATUS_FULL)
        else $error("table write without a matching result");

    // a dropped fill reports zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STATUS_FULL |->
            result.slot == '0 && result.net_position == '0 && result.average_cost == '0)
        else $error("dropped fill with nonzero fields");

endmodule
